// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// concurrent check, masked while reset is high
`define ASSERT_CHECK(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("%m: check failed");
// concurrent check that also runs during reset
`define ASSERT_RESET(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) \
    else $error("%m: reset check failed");
`else
`define ASSERT_CHECK(label, clk_s, rst_s, prop)
`define ASSERT_RESET(label, clk_s, prop)
`endif
`endif

// ===== sv/ghd_pkg.sv =====
// shared widths, constants and tables of the grid haversine distance unit
package ghd_pkg;

  // port field widths
  localparam int IN_W      = 12;
  localparam int REG_W     = 13;
  localparam int OUT_W     = 19;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 24;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;

  localparam logic [REG_W-1:0] GRID_COLUMNS_RESET = 13'd709;
  localparam logic [REG_W-1:0] GRID_ROWS_RESET    = 13'd500;
  localparam logic [REG_W-1:0] GRID_MIN           = 13'd2;

  // phase divider: dividend is {numerator, 32-bit fraction}
  localparam int NUM_W     = 25;
  localparam int DEN_W     = 15;
  localparam int PH_W      = 32;
  localparam int DVD_W     = NUM_W + PH_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int NLANE     = 4;

  // lanes of the phase and sine path
  localparam int LANE_LON  = 0;
  localparam int LANE_LAT  = 1;
  localparam int LANE_COS1 = 2;
  localparam int LANE_COS2 = 3;

  // q2.30 datapath
  localparam int QW           = 31;
  localparam int CW           = 34;
  localparam int ZW           = 33;
  localparam int CORDIC_STEPS = 30;
  localparam int SQ_W         = 62;
  localparam int SQRT_STEPS   = 31;

  localparam logic [PH_W-1:0]      PI_Q30       = 32'd3373259426;
  localparam logic [QW-1:0]        HALF_PI_Q30  = 31'd1686629713;
  localparam logic signed [CW-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic [QW-1:0]        ONE_Q30      = 31'h4000_0000;
  localparam logic [17:0]          DIST_SCALE   = 18'd203872;
  localparam logic [OUT_W-1:0]     SPAN_MAX     = 19'd320255;

  // arctangent of 2^-i in q2.30
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
  };

endpackage

// ===== sv/grid_haversine_distance_unit.sv =====
// top level: great-circle distance between two map grid cells
// throughput: one pair per cycle while the skid entry is empty; the whole pipeline
//   moves together through the 57-step phase divider, a 30-step sine cordic chain
//   per lane, two 31-step square roots and a 30-step arctangent cordic chain
// a two-entry output (register plus skid) keeps input open while a result waits
// reset: synchronous, clears all valid flags and loads 709 columns, 500 rows
`include "assert_macros.svh"
module grid_haversine_distance_unit import ghd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // first_column[11:0], first_row[23:12], second_column[35:24], second_row[47:36]
  input  logic [S_DATA_W-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // distance_sixteenths_km[18:0], zero fill above
  output logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int PIPE_DEPTH = 1 + DIV_STEPS + 2 + CORDIC_STEPS + 4 + SQRT_STEPS
                              + CORDIC_STEPS + 2;
  localparam logic signed [CW-1:0] Y_MAX = $signed({3'b000, ONE_Q30});
  localparam logic signed [CW-1:0] Y_MIN = -Y_MAX;
  localparam logic [2*QW-1:0] RND_PROD = {{(2*QW-1){1'b0}}, 1'b1} << 29;

  logic [REG_W-1:0]      grid_columns;
  logic [REG_W-1:0]      grid_rows;
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  logic                  tail_vld;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_data;
  logic                  skid_valid;
  logic [OUT_W-1:0]      skid_data;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= GRID_COLUMNS_RESET;
      grid_rows    <= GRID_ROWS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_COLUMNS: grid_columns <= cfg_data;
        CFG_GRID_ROWS:    grid_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves unless the skid entry is occupied
  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  assign tail_vld = vld[PIPE_DEPTH-1];

  // entry: build dividends {n, fraction with half divisor} per lane
  logic [REG_W-1:0] cols;
  logic [REG_W-1:0] rows;
  logic [DEN_W-1:0] ent_den [NLANE];
  logic [NUM_W-1:0] ent_num [NLANE];
  logic [IN_W:0]    dx;
  logic [IN_W:0]    dy;
  logic [DVD_W-1:0] dvd0 [NLANE];
  logic [DEN_W-1:0] den0 [NLANE];

  always_comb begin
    cols = (grid_columns < GRID_MIN) ? GRID_MIN : grid_columns;
    rows = (grid_rows < GRID_MIN) ? GRID_MIN : grid_rows;
    dx = {1'b0, s_tdata[11:0]} - {1'b0, s_tdata[35:24]};
    dy = {1'b0, s_tdata[23:12]} - {1'b0, s_tdata[47:36]};
    ent_den[LANE_LON]  = {1'b0, cols, 1'b0};
    ent_den[LANE_LAT]  = {rows, 2'b00};
    ent_den[LANE_COS1] = {1'b0, rows, 1'b0};
    ent_den[LANE_COS2] = {1'b0, rows, 1'b0};
    // adding 1024 divisors keeps every numerator positive
    ent_num[LANE_LON]  = {ent_den[LANE_LON], {(NUM_W-DEN_W){1'b0}}}
                         + {{(NUM_W-IN_W-1){dx[IN_W]}}, dx};
    ent_num[LANE_LAT]  = {ent_den[LANE_LAT], {(NUM_W-DEN_W){1'b0}}}
                         + {{(NUM_W-IN_W-1){dy[IN_W]}}, dy};
    ent_num[LANE_COS1] = {ent_den[LANE_COS1], {(NUM_W-DEN_W){1'b0}}}
                         + {{(NUM_W-IN_W){1'b0}}, s_tdata[23:12]};
    ent_num[LANE_COS2] = {ent_den[LANE_COS2], {(NUM_W-DEN_W){1'b0}}}
                         + {{(NUM_W-IN_W){1'b0}}, s_tdata[47:36]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        den0[l] <= ent_den[l];
        dvd0[l] <= {ent_num[l], {(PH_W-DEN_W+1){1'b0}}, ent_den[l][DEN_W-1:1]};
      end
    end
  end

  // phase dividers: low 32 quotient bits give the turn fraction
  logic [DVD_W-1:0] dvd [NLANE][DIV_STEPS+1];
  logic [DEN_W-1:0] den [NLANE][DIV_STEPS+1];
  logic [DEN_W-1:0] rem [NLANE][DIV_STEPS+1];
  logic [PH_W-1:0]  quo [NLANE][DIV_STEPS+1];

  for (genvar l = 0; l < NLANE; l++) begin : g_div_lane
    assign dvd[l][0] = dvd0[l];
    assign den[l][0] = den0[l];
    assign rem[l][0] = '0;
    assign quo[l][0] = '0;
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div_step
      ghd_div_cell u_cell (
        .clk     (clk),
        .en      (en),
        .dvd_in  (dvd[l][s]),
        .den_in  (den[l][s]),
        .rem_in  (rem[l][s]),
        .quo_in  (quo[l][s]),
        .dvd_out (dvd[l][s+1]),
        .den_out (den[l][s+1]),
        .rem_out (rem[l][s+1]),
        .quo_out (quo[l][s+1])
      );
    end
  end

  // fold the phase into a quarter turn either side of zero
  logic [PH_W-1:0] pf    [NLANE];
  logic [PH_W-1:0] pmag  [NLANE];
  logic [QW-1:0]   fmag  [NLANE];
  logic            fneg  [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (quo[l][DIV_STEPS][PH_W-1:PH_W-2] == 2'd1 ||
          quo[l][DIV_STEPS][PH_W-1:PH_W-2] == 2'd2) begin
        pf[l] = 32'h8000_0000 - quo[l][DIV_STEPS];
      end else begin
        pf[l] = quo[l][DIV_STEPS];
      end
      pmag[l] = pf[l][PH_W-1] ? (32'd0 - pf[l]) : pf[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        fmag[l] <= pmag[l][QW-1:0];
        fneg[l] <= pf[l][PH_W-1];
      end
    end
  end

  // turn fraction to q2.30 radians, rounded, sign applied after
  logic [QW+PH_W-1:0] radp [NLANE];
  logic [ZW-1:0]      radm [NLANE];
  logic [ZW-1:0]      rad0 [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      radp[l] = ({{PH_W{1'b0}}, fmag[l]} * {{QW{1'b0}}, PI_Q30})
                + ({{(QW+PH_W-1){1'b0}}, 1'b1} << 30);
      radm[l] = {2'b00, radp[l][QW+PH_W-2:31]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        rad0[l] <= fneg[l] ? ({ZW{1'b0}} - radm[l]) : radm[l];
      end
    end
  end

  // sine chains, one per lane
  logic signed [CW-1:0] sx [NLANE][CORDIC_STEPS+1];
  logic signed [CW-1:0] sy [NLANE][CORDIC_STEPS+1];
  logic signed [ZW-1:0] sz [NLANE][CORDIC_STEPS+1];

  for (genvar l = 0; l < NLANE; l++) begin : g_sin_lane
    assign sx[l][0] = GAIN_INV_Q30;
    assign sy[l][0] = '0;
    assign sz[l][0] = $signed(rad0[l]);
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_sin_step
      ghd_cordic_cell #(
        .STEP      (s),
        .VECTORING (1'b0)
      ) u_cell (
        .clk   (clk),
        .en    (en),
        .x_in  (sx[l][s]),
        .y_in  (sy[l][s]),
        .z_in  (sz[l][s]),
        .x_out (sx[l][s+1]),
        .y_out (sy[l][s+1]),
        .z_out (sz[l][s+1])
      );
    end
  end

  // clamp sines to +-1 and split into sign and magnitude
  logic signed [CW-1:0] ysat [NLANE];
  logic [CW-1:0]        yabs [NLANE];
  logic [QW-1:0]        smag [NLANE];
  logic                 sneg [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (sy[l][CORDIC_STEPS] > Y_MAX) begin
        ysat[l] = Y_MAX;
      end else if (sy[l][CORDIC_STEPS] < Y_MIN) begin
        ysat[l] = Y_MIN;
      end else begin
        ysat[l] = sy[l][CORDIC_STEPS];
      end
      yabs[l] = ysat[l][CW-1] ? ({CW{1'b0}} - ysat[l]) : ysat[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        smag[l] <= yabs[l][QW-1:0];
        sneg[l] <= ysat[l][CW-1];
      end
    end
  end

  // squares of the half-angle sines and the cosine product
  logic [2*QW-1:0] p_lon;
  logic [2*QW-1:0] p_lat;
  logic [2*QW-1:0] p_cos;
  logic [QW-1:0]   hav_lon;
  logic [QW-1:0]   hav_lat;
  logic [QW-1:0]   ccmag;
  logic            ccneg;

  assign p_lon = smag[LANE_LON] * smag[LANE_LON] + RND_PROD;
  assign p_lat = smag[LANE_LAT] * smag[LANE_LAT] + RND_PROD;
  assign p_cos = smag[LANE_COS1] * smag[LANE_COS2] + RND_PROD;

  always_ff @(posedge clk) begin
    if (en) begin
      hav_lon <= p_lon[QW+29:30];
      hav_lat <= p_lat[QW+29:30];
      ccmag   <= p_cos[QW+29:30];
      ccneg   <= sneg[LANE_COS1] ^ sneg[LANE_COS2];
    end
  end

  // cosine product times longitude term
  logic [2*QW-1:0]     p_term;
  logic [QW:0]         term_abs;
  logic signed [QW:0]  term;
  logic [QW-1:0]       hav_lat_d;

  assign p_term   = ccmag * hav_lon + RND_PROD;
  assign term_abs = {1'b0, p_term[QW+29:30]};

  always_ff @(posedge clk) begin
    if (en) begin
      term      <= ccneg ? $signed({(QW+1){1'b0}} - term_abs) : $signed(term_abs);
      hav_lat_d <= hav_lat;
    end
  end

  // a = lat term + lon term, clamped to [0, 1]
  logic signed [QW+1:0] a_sum;
  logic [QW-1:0]        a_clip;
  logic [QW-1:0]        a_val;
  logic [QW-1:0]        b_val;

  always_comb begin
    a_sum = $signed({2'b00, hav_lat_d}) + $signed({term[QW], term});
    if (a_sum[QW+1]) begin
      a_clip = '0;
    end else if (a_sum > $signed({2'b00, ONE_Q30})) begin
      a_clip = ONE_Q30;
    end else begin
      a_clip = a_sum[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_val <= a_clip;
      b_val <= ONE_Q30 - a_clip;
    end
  end

  // square roots of a and 1-a, q2.30
  logic [SQ_W-1:0] va [SQRT_STEPS+1];
  logic [SQ_W-1:0] ra [SQRT_STEPS+1];
  logic [SQ_W-1:0] vb [SQRT_STEPS+1];
  logic [SQ_W-1:0] rb [SQRT_STEPS+1];

  assign va[0] = {1'b0, a_val, 30'd0};
  assign vb[0] = {1'b0, b_val, 30'd0};
  assign ra[0] = '0;
  assign rb[0] = '0;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt_step
    ghd_sqrt_cell #(
      .K (SQRT_STEPS - 1 - s)
    ) u_cell_a (
      .clk   (clk),
      .en    (en),
      .v_in  (va[s]),
      .r_in  (ra[s]),
      .v_out (va[s+1]),
      .r_out (ra[s+1])
    );
    ghd_sqrt_cell #(
      .K (SQRT_STEPS - 1 - s)
    ) u_cell_b (
      .clk   (clk),
      .en    (en),
      .v_in  (vb[s]),
      .r_in  (rb[s]),
      .v_out (vb[s+1]),
      .r_out (rb[s+1])
    );
  end

  // angle = atan2(sqrt(a), sqrt(1-a))
  logic signed [CW-1:0] ax [CORDIC_STEPS+1];
  logic signed [CW-1:0] ay [CORDIC_STEPS+1];
  logic signed [ZW-1:0] az [CORDIC_STEPS+1];

  assign ax[0] = $signed({3'b000, rb[SQRT_STEPS][QW-1:0]});
  assign ay[0] = $signed({3'b000, ra[SQRT_STEPS][QW-1:0]});
  assign az[0] = '0;

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_atan_step
    ghd_cordic_cell #(
      .STEP      (s),
      .VECTORING (1'b1)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (ax[s]),
      .y_in  (ay[s]),
      .z_in  (az[s]),
      .x_out (ax[s+1]),
      .y_out (ay[s+1]),
      .z_out (az[s+1])
    );
  end

  // clamp angle to [0, pi/2], then scale by 2*R*16 with rounding
  logic [QW-1:0]      z_clip;
  logic [QW-1:0]      z_val;
  logic [QW+17:0]     p_span;
  logic [OUT_W-1:0]   span;

  always_comb begin
    if (az[CORDIC_STEPS][ZW-1]) begin
      z_clip = '0;
    end else if (az[CORDIC_STEPS] > $signed({2'b00, HALF_PI_Q30})) begin
      z_clip = HALF_PI_Q30;
    end else begin
      z_clip = az[CORDIC_STEPS][QW-1:0];
    end
  end

  assign p_span = ({18'd0, z_val} * {{QW{1'b0}}, DIST_SCALE})
                  + ({{(QW+17){1'b0}}, 1'b1} << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      z_val <= z_clip;
      span  <= p_span[QW+17:30];
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= vld[PIPE_DEPTH-1];
        out_data  <= span;
      end
    end else if (vld[PIPE_DEPTH-1] && en) begin
      skid_valid <= 1'b1;
      skid_data  <= span;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W-OUT_W){1'b0}}, out_data};

  `ASSERT_CHECK(a_skid_needs_out, clk, rst, skid_valid |-> out_valid)
  `ASSERT_CHECK(a_no_accept_on_skid, clk, rst, skid_valid |-> !s_tready)
  `ASSERT_CHECK(a_stall_to_skid, clk, rst, (tail_vld && en && out_valid && !m_tready) |=> skid_valid)
  `ASSERT_CHECK(a_span_range, clk, rst, out_valid |-> (out_data <= SPAN_MAX))
  `ASSERT_RESET(a_reset_empty, clk, rst |=> (!out_valid && !skid_valid))

endmodule

// ===== sv/ghd_div_cell.sv =====
// one restoring division step of the phase divider chain
module ghd_div_cell import ghd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dvd_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [PH_W-1:0]  quo_in,
  output logic [DVD_W-1:0] dvd_out,
  output logic [DEN_W-1:0] den_out,
  output logic [DEN_W-1:0] rem_out,
  output logic [PH_W-1:0]  quo_out
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  // bring down the next dividend bit and try the subtract
  assign trial = {rem_in, dvd_in[DVD_W-1]};
  assign diff  = trial - {1'b0, den_in};
  assign ge    = (trial >= {1'b0, den_in});

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_out <= {dvd_in[DVD_W-2:0], 1'b0};
      den_out <= den_in;
      rem_out <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_out <= {quo_in[PH_W-2:0], ge};
    end
  end

endmodule

// ===== sv/ghd_cordic_cell.sv =====
// one micro-rotation of a cordic chain, rotation or vectoring mode
module ghd_cordic_cell import ghd_pkg::*; #(
  parameter int STEP      = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  localparam logic signed [ZW-1:0] ANG = $signed({3'b000, ATAN_TAB[STEP]});

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic                 turn_up;

  // arithmetic shifts round toward minus infinity
  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  // rotation follows the sign of z, vectoring drives y toward zero
  assign turn_up = VECTORING ? y_in[CW-1] : !z_in[ZW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (turn_up) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ANG;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ANG;
      end
    end
  end

endmodule

// ===== sv/ghd_sqrt_cell.sv =====
// one bit pair of the floor square root chain
module ghd_sqrt_cell import ghd_pkg::*; #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] v_in,
  input  logic [SQ_W-1:0] r_in,
  output logic [SQ_W-1:0] v_out,
  output logic [SQ_W-1:0] r_out
);

  localparam logic [SQ_W-1:0] BIT_V = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * K);

  logic [SQ_W-1:0] trial;
  logic            ge;

  assign trial = r_in + BIT_V;
  assign ge    = (v_in >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= ge ? (v_in - trial) : v_in;
      r_out <= ge ? ((r_in >> 1) + BIT_V) : (r_in >> 1);
    end
  end

endmodule

// ===== test/tb.sv =====
// testbench for the grid haversine distance unit: directed and random pairs against a predictor
`timescale 1ns / 100ps
module tb;
  import ghd_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // first_column[11:0], first_row[23:12], second_column[35:24], second_row[47:36]
  logic [S_DATA_W-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  // distance_sixteenths_km[18:0], zero fill above
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  grid_haversine_distance_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  // register indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // shadow copy of the grid registers
  logic [REG_W-1:0] columns_reg;
  logic [REG_W-1:0] rows_reg;

  logic [OUT_W-1:0] expected_distances[$];
  int  error_count;
  int  pairs_sent;
  int  distances_seen;
  int  cycle_count;
  bit  quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- distance predictor ----------------

  function automatic bit [31:0] turn_phase(bit [63:0] num, bit [63:0] den);
    bit [63:0] t;
    t = ((num << 32) + den / 2) / den;
    return t[31:0];
  endfunction

  function automatic longint wrap_index(longint d, longint m);
    longint r;
    r = d % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic longint q30_product(longint a, longint b);
    bit        neg;
    bit [63:0] ma;
    bit [63:0] mb;
    bit [63:0] m;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint rotate_sine(longint z);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = longint'(GAIN_INV_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
    if (y < -(64'sd1 << 30)) y = -(64'sd1 << 30);
    return y;
  endfunction

  function automatic longint sine_of_turn(bit [31:0] p);
    bit        neg;
    bit [63:0] mag;
    longint    rad;
    if (p[31:30] == 2'd1 || p[31:30] == 2'd2) p = 32'h8000_0000 - p;
    neg = p[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, p}) : {32'd0, p};
    rad = longint'((mag * 64'(PI_Q30) + (64'd1 << 30)) >> 31);
    return rotate_sine(neg ? -rad : rad);
  endfunction

  function automatic bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [OUT_W-1:0] predict_distance(logic [S_DATA_W-1:0] pair);
    longint    cols;
    longint    rows;
    longint    x1, y1, x2, y2;
    longint    s, hav_lon, hav_lat, c1, c2, a, z;
    bit [63:0] ra, rb, d;
    cols = (columns_reg < GRID_MIN) ? 2 : longint'(columns_reg);
    rows = (rows_reg < GRID_MIN) ? 2 : longint'(rows_reg);
    x1 = pair[11:0];
    y1 = pair[23:12];
    x2 = pair[35:24];
    y2 = pair[47:36];
    s = sine_of_turn(turn_phase(wrap_index(x1 - x2, 2 * cols), 2 * cols));
    hav_lon = q30_product(s, s);
    s = sine_of_turn(turn_phase(wrap_index(y1 - y2, 4 * rows), 4 * rows));
    hav_lat = q30_product(s, s);
    c1 = sine_of_turn(turn_phase(wrap_index(y1, 2 * rows), 2 * rows));
    c2 = sine_of_turn(turn_phase(wrap_index(y2, 2 * rows), 2 * rows));
    a = hav_lat + q30_product(q30_product(c1, c2), hav_lon);
    if (a < 0) a = 0;
    if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
    ra = floor_root(64'(a) << 30);
    rb = floor_root(64'((64'sd1 << 30) - a) << 30);
    z = vector_angle(longint'(rb), longint'(ra));
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    d = (64'(z) * 64'(DIST_SCALE) + (64'd1 << 29)) >> 30;
    return d[OUT_W-1:0];
  endfunction

  // ---------------- monitors ----------------

  // record the expected distance of every accepted pair
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_distances.push_back(predict_distance(s_tdata));
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      distances_seen++;
      if (expected_distances.size() == 0) begin
        $error("distance_sixteenths_km: unexpected result %0d", m_tdata[OUT_W-1:0]);
        error_count++;
      end else begin
        want = expected_distances.pop_front();
        if (m_tdata[OUT_W-1:0] !== want) begin
          $error("distance_sixteenths_km expected %0d actual %0d", want,
                 m_tdata[OUT_W-1:0]);
          error_count++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[grid_haversine_distance_unit] ERROR");
      $finish;
    end
  end

  // ---------------- shared tasks ----------------

  // one pair transfer; valid stays high into the next pair unless a gap is taken
  task automatic send_pair(logic [IN_W-1:0] x1, logic [IN_W-1:0] y1,
                           logic [IN_W-1:0] x2, logic [IN_W-1:0] y2);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y2, x2, y1, x1};
    do @(posedge clk); while (!s_tready);
    pairs_sent++;
  endtask

  task automatic send_random_pair();
    if ($urandom_range(0, 3) == 0)
      send_pair(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
    else
      send_pair(IN_W'($urandom_range(0, columns_reg)), IN_W'($urandom_range(0, rows_reg)),
                IN_W'($urandom_range(0, columns_reg)), IN_W'($urandom_range(0, rows_reg)));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write on the configuration channel, only with the pipeline empty
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRID_COLUMNS) columns_reg = value;
    else if (idx == CFG_GRID_ROWS) rows_reg = value;
  endtask

  task automatic set_grid(logic [REG_W-1:0] cols, logic [REG_W-1:0] rows);
    write_register(CFG_GRID_COLUMNS, cols);
    write_register(CFG_GRID_ROWS, rows);
  endtask

  // ---------------- tests ----------------

  // corners, poles, antipodes and indexes beyond the grid at reset values
  task automatic test_directed_points();
    send_pair(0, 0, 0, 0);
    send_pair(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_pair(0, 0, 12'hFFF, 12'hFFF);
    send_pair(12'hFFF, 0, 0, 12'hFFF);
    send_pair(354, 250, 354, 250);
    send_pair(0, 250, 354, 250);
    send_pair(100, 0, 100, 500);
    send_pair(0, 125, 354, 375);
    send_pair(708, 499, 0, 0);
    send_pair(709, 500, 0, 0);
    send_pair(1418, 1000, 3000, 4000);
    send_pair(12'hAAA, 12'h555, 12'h555, 12'hAAA);
    send_pair(1, 1, 2, 2);
  endtask

  // unknown index is ignored, registers below two act as two, extremes of the range
  task automatic test_register_edges();
    write_register(CFG_SPARE_A, 13'h1FFF);
    write_register(CFG_SPARE_B, 13'd0);
    send_pair(354, 250, 0, 0);
    set_grid(0, 1);
    send_pair(0, 0, 1, 1);
    send_pair(1, 0, 0, 1);
    send_pair(12'hFFF, 12'h800, 3, 7);
    set_grid(2, 2);
    send_pair(0, 0, 1, 1);
    send_pair(1, 2, 0, 0);
    set_grid(13'h1FFF, 13'h1FFF);
    send_pair(0, 0, 12'hFFF, 12'hFFF);
    send_pair(12'hFFF, 0, 0, 12'hFFF);
    set_grid(4096, 4096);
    send_pair(0, 0, 2048, 4095);
  endtask

  task automatic test_random_grid(logic [REG_W-1:0] cols, logic [REG_W-1:0] rows, int n);
    set_grid(cols, rows);
    repeat (n) send_random_pair();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRID_COLUMNS;
    cfg_data = '0;
    quiet = 1'b0;
    error_count = 0;
    pairs_sent = 0;
    distances_seen = 0;
    cycle_count = 0;
    columns_reg = GRID_COLUMNS_RESET;
    rows_reg = GRID_ROWS_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_points();
    test_register_edges();
    test_random_grid(709, 500, 300);
    test_random_grid(2, 2, 200);
    test_random_grid(4096, 4096, 300);
    test_random_grid(360, 180, 300);
    test_random_grid(13'h1FFF, 13'd3, 200);
    test_random_grid(1, 4096, 200);
    test_random_grid(REG_W'($urandom_range(2, 4096)), REG_W'($urandom_range(2, 4096)), 300);
    quiet = 1'b1;
    repeat (200) send_random_pair();
    wait_idle();

    $display("run covered %0d pairs and %0d distances over reset, fixed and random grids,",
             pairs_sent, distances_seen);
    $display("including degenerate, maximal and out-of-range register values");
    if (error_count == 0) begin
      $display("[grid_haversine_distance_unit] OK");
    end else begin
      $display("[grid_haversine_distance_unit] ERROR");
    end
    $finish;
  end

endmodule
